// ===== rtl/epd_pkg.sv =====
// ----------------------------------------------------------------------------
// epd_pkg: shared types and constants of the encoder position PID drive
// Field widths, register indexes, reset values, item types and the command
// and status records of the shared arithmetic unit.
// ----------------------------------------------------------------------------
package epd_pkg;

    // Field widths
    localparam int EPD_ADC_W    = 10;
    localparam int EPD_EL_W     = 24;
    localparam int EPD_GAIN_W   = 24;
    localparam int EPD_ANGLE_W  = 16;
    localparam int EPD_CTL_W    = 32;
    localparam int EPD_DRIVE_W  = 8;
    localparam int EPD_COUNT_W  = 32;

    // Full-scale code of the target converter
    localparam int EPD_ADC_MAX  = 1023;

    // Configuration port
    localparam int EPD_CFG_IDX_W  = 3;
    localparam int EPD_CFG_DATA_W = 24;

    localparam logic [EPD_CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd0;
    localparam logic [EPD_CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd1;
    localparam logic [EPD_CFG_IDX_W-1:0] CFG_INTEG_GAIN = 3'd2;
    localparam logic [EPD_CFG_IDX_W-1:0] CFG_FULL_SCALE = 3'd3;
    localparam logic [EPD_CFG_IDX_W-1:0] CFG_ANGLE_SPAN = 3'd4;

    localparam logic [EPD_GAIN_W-1:0]  RST_PROP_GAIN  = 24'd65536;
    localparam logic [EPD_GAIN_W-1:0]  RST_DERIV_GAIN = 24'd1638;
    localparam logic [EPD_GAIN_W-1:0]  RST_INTEG_GAIN = 24'd0;
    localparam logic [EPD_ANGLE_W-1:0] RST_FULL_SCALE = 16'd2527;
    localparam logic [EPD_ANGLE_W-1:0] RST_ANGLE_SPAN = 16'd180;

    localparam logic [EPD_DRIVE_W-1:0] EPD_DRIVE_FULL = 8'd255;

    // Item operation codes
    localparam logic OP_ENC_EDGE = 1'b0;
    localparam logic OP_TICK     = 1'b1;

    // Shared arithmetic unit: 64-bit magnitude by 24-bit operand
    localparam int EPD_ALU_A_W   = 64;
    localparam int EPD_ALU_B_W   = 24;
    localparam int EPD_ALU_RES_W = EPD_ALU_A_W + EPD_ALU_B_W;
    localparam int EPD_MUL_STEPS = EPD_ALU_B_W;
    localparam int EPD_DIV_STEPS = EPD_ALU_A_W;

    localparam logic ALU_OP_MUL = 1'b0;
    localparam logic ALU_OP_DIV = 1'b1;

    typedef struct packed {
        logic                   op;
        logic                   phase_b_level;
        logic [EPD_ADC_W-1:0]   target_adc;
        logic [EPD_EL_W-1:0]    elapsed_us;
    } t_in_item;

    typedef struct packed {
        logic                          direction;
        logic [EPD_DRIVE_W-1:0]        drive_level;
        logic signed [EPD_CTL_W-1:0]   control_value;
        logic [EPD_ANGLE_W-1:0]        target_angle;
        logic signed [EPD_CTL_W-1:0]   position_angle;
    } t_out_item;

    typedef struct packed {
        logic [EPD_GAIN_W-1:0]  prop_gain;
        logic [EPD_GAIN_W-1:0]  deriv_gain;
        logic [EPD_GAIN_W-1:0]  integ_gain;
        logic [EPD_ANGLE_W-1:0] full_scale;
        logic [EPD_ANGLE_W-1:0] angle_span;
    } t_cfg;

    typedef struct packed {
        logic                    start;
        logic                    op;
        logic [EPD_ALU_A_W-1:0]  a;
        logic [EPD_ALU_B_W-1:0]  b;
    } t_alu_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_stat;

    typedef struct packed {
        logic busy;
        logic res_valid;
    } t_ctrl_stat;

endpackage

// ===== rtl/epd_in_if.sv =====
// ----------------------------------------------------------------------------
// epd_in_if: input item channel
// Valid/ready channel that carries one encoder edge or control tick.
// ----------------------------------------------------------------------------
interface epd_in_if;
    logic               valid;
    logic               ready;
    epd_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/epd_out_if.sv =====
// ----------------------------------------------------------------------------
// epd_out_if: result item channel
// Valid/ready channel that carries one drive result per control tick.
// ----------------------------------------------------------------------------
interface epd_out_if;
    logic                valid;
    logic                ready;
    epd_pkg::t_out_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/encoder_position_pid_drive_core.sv =====
// ----------------------------------------------------------------------------
// encoder_position_pid_drive_core: position PID drive with encoder counter
// Encoder edges move the position counter; control ticks run a
// serial multiply/divide sequence and give one drive result each.
// ----------------------------------------------------------------------------
// Sequence: a control tick runs 7 multiplies and 4 divides through the
//   single shift-add / restoring unit; the derivative multiply and divide
//   are skipped when elapsed_us is zero.
// Flow: input is not ready during a tick, so a new item waits until it ends.
//   The output register lets the next item in while a result waits.
// Reset: synchronous, active low; clears counter, integral, previous error.
module encoder_position_pid_drive_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    epd_in_if.sink                                  i_in,
    epd_out_if.source                               o_out,
    input  logic                                    i_cfg_wr_en,
    input  logic [epd_pkg::EPD_CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [epd_pkg::EPD_CFG_DATA_W-1:0]      i_cfg_wdata
);

    localparam int CNT_W = epd_pkg::EPD_COUNT_W;

    epd_pkg::t_cfg                 r_cfg;
    logic signed [CNT_W-1:0]       r_count;
    logic                          r_out_valid;
    epd_pkg::t_out_item            r_out_data;

    epd_pkg::t_ctrl_stat           w_stat;
    epd_pkg::t_out_item            w_res;
    logic                          w_accept;
    logic                          w_take;

    assign i_in.ready = !w_stat.busy;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_take     = !r_out_valid || o_out.ready;

    // Configuration registers, back to their defaults on reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain  <= epd_pkg::RST_PROP_GAIN;
            r_cfg.deriv_gain <= epd_pkg::RST_DERIV_GAIN;
            r_cfg.integ_gain <= epd_pkg::RST_INTEG_GAIN;
            r_cfg.full_scale <= epd_pkg::RST_FULL_SCALE;
            r_cfg.angle_span <= epd_pkg::RST_ANGLE_SPAN;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                epd_pkg::CFG_PROP_GAIN:  r_cfg.prop_gain  <= i_cfg_wdata;
                epd_pkg::CFG_DERIV_GAIN: r_cfg.deriv_gain <= i_cfg_wdata;
                epd_pkg::CFG_INTEG_GAIN: r_cfg.integ_gain <= i_cfg_wdata;
                epd_pkg::CFG_FULL_SCALE:
                    r_cfg.full_scale <= i_cfg_wdata[epd_pkg::EPD_ANGLE_W-1:0];
                epd_pkg::CFG_ANGLE_SPAN:
                    r_cfg.angle_span <= i_cfg_wdata[epd_pkg::EPD_ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Encoder position counter, wraps modulo 2^32.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept && i_in.data.op == epd_pkg::OP_ENC_EDGE) begin
            if (i_in.data.phase_b_level) begin
                r_count <= r_count + 1'b1;
            end else begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    epd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept && i_in.data.op == epd_pkg::OP_TICK),
        .i_adc       (i_in.data.target_adc),
        .i_el        (i_in.data.elapsed_us),
        .i_count     (r_count),
        .i_cfg       (r_cfg),
        .i_res_ready (w_take),
        .o_stat      (w_stat),
        .o_res       (w_res)
    );

    // Output register between the sequencer and the result channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= w_stat.res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_stat.res_valid) begin
            r_out_data <= w_res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // An accepted encoder edge always moves the counter.
    a_count_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.data.op == epd_pkg::OP_ENC_EDGE) |=> (r_count != $past(r_count)))
        else $error("encoder edge did not move the counter");

    // An accepted control tick starts the sequencer.
    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.data.op == epd_pkg::OP_TICK) |=> w_stat.busy)
        else $error("control tick did not start the sequencer");

endmodule

// ===== rtl/epd_alu.sv =====
// ----------------------------------------------------------------------------
// epd_alu: shared serial multiply / divide unit
// Shift-add multiply of a 64-bit magnitude by a 24-bit operand (24 steps) and
// restoring divide of a 64-bit magnitude by a 24-bit divisor (64 steps).
// Product is {hi, lo}; the quotient is left in hi, the remainder in lo.
// ----------------------------------------------------------------------------
module epd_alu (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  epd_pkg::t_alu_cmd                     i_cmd,
    output epd_pkg::t_alu_stat                    o_stat,
    output logic [epd_pkg::EPD_ALU_RES_W-1:0]     o_result
);

    localparam int A_W   = epd_pkg::EPD_ALU_A_W;
    localparam int B_W   = epd_pkg::EPD_ALU_B_W;
    localparam int CNT_W = $clog2(epd_pkg::EPD_DIV_STEPS);

    logic             r_run;
    logic             r_done;
    logic             r_op;
    logic [CNT_W-1:0] r_cnt;
    logic [A_W-1:0]   r_hi;
    logic [B_W-1:0]   r_lo;
    logic [A_W-1:0]   r_opnd;

    logic [A_W-1:0]   n_hi;
    logic [B_W-1:0]   n_lo;

    logic [A_W:0]     w_add;
    logic [B_W:0]     w_trial;
    logic [B_W:0]     w_sub;
    logic             w_ge;
    logic             w_load;

    assign w_load = i_cmd.start && !r_run;

    // One step of either operation.
    always_comb begin
        w_add   = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_opnd} : {(A_W+1){1'b0}});
        w_trial = {r_lo, r_hi[A_W-1]};
        w_ge    = w_trial >= {1'b0, r_opnd[B_W-1:0]};
        w_sub   = w_trial - {1'b0, r_opnd[B_W-1:0]};
        if (r_op == epd_pkg::ALU_OP_MUL) begin
            n_hi = w_add[A_W:1];
            n_lo = {w_add[0], r_lo[B_W-1:1]};
        end else begin
            n_hi = {r_hi[A_W-2:0], w_ge};
            n_lo = w_ge ? w_sub[B_W-1:0] : w_trial[B_W-1:0];
        end
    end

    // Step counter and completion flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (w_load) begin
                r_run <= 1'b1;
                r_cnt <= (i_cmd.op == epd_pkg::ALU_OP_MUL)
                         ? CNT_W'(epd_pkg::EPD_MUL_STEPS - 1)
                         : CNT_W'(epd_pkg::EPD_DIV_STEPS - 1);
            end else if (r_run) begin
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_op <= i_cmd.op;
            if (i_cmd.op == epd_pkg::ALU_OP_MUL) begin
                r_hi   <= '0;
                r_lo   <= i_cmd.b;
                r_opnd <= i_cmd.a;
            end else begin
                r_hi   <= i_cmd.a;
                r_lo   <= '0;
                r_opnd <= {{(A_W-B_W){1'b0}}, i_cmd.b};
            end
        end else if (r_run) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    assign o_stat.busy = r_run;
    assign o_stat.done = r_done;
    assign o_result    = {r_hi, r_lo};

endmodule

// ===== rtl/epd_ctrl.sv =====
// ----------------------------------------------------------------------------
// epd_ctrl: control tick sequencer
// Walks one control tick through the shared multiply/divide unit: position
// and target mapping, error, derivative, integral and the weighted sum.
// Holds the previous error and the error-time integral between ticks.
// ----------------------------------------------------------------------------
module epd_ctrl (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_start,
    input  logic [epd_pkg::EPD_ADC_W-1:0]             i_adc,
    input  logic [epd_pkg::EPD_EL_W-1:0]              i_el,
    input  logic signed [epd_pkg::EPD_COUNT_W-1:0]    i_count,
    input  epd_pkg::t_cfg                             i_cfg,
    input  logic                                      i_res_ready,
    output epd_pkg::t_ctrl_stat                       o_stat,
    output epd_pkg::t_out_item                        o_res
);

    localparam int A_W   = epd_pkg::EPD_ALU_A_W;
    localparam int B_W   = epd_pkg::EPD_ALU_B_W;
    localparam int R_W   = epd_pkg::EPD_ALU_RES_W;
    localparam int C_W   = epd_pkg::EPD_CTL_W;
    localparam int ST_W  = 4;

    localparam logic [ST_W-1:0] ST_IDLE    = 4'd0;
    localparam logic [ST_W-1:0] ST_POS_MUL = 4'd1;
    localparam logic [ST_W-1:0] ST_POS_DIV = 4'd2;
    localparam logic [ST_W-1:0] ST_TGT_MUL = 4'd3;
    localparam logic [ST_W-1:0] ST_TGT_DIV = 4'd4;
    localparam logic [ST_W-1:0] ST_DER_MUL = 4'd5;
    localparam logic [ST_W-1:0] ST_DER_DIV = 4'd6;
    localparam logic [ST_W-1:0] ST_ETS_MUL = 4'd7;
    localparam logic [ST_W-1:0] ST_P_MUL   = 4'd8;
    localparam logic [ST_W-1:0] ST_D_MUL   = 4'd9;
    localparam logic [ST_W-1:0] ST_I_MUL   = 4'd10;
    localparam logic [ST_W-1:0] ST_I_DIV   = 4'd11;
    localparam logic [ST_W-1:0] ST_DONE    = 4'd12;

    localparam logic [B_W-1:0] ADC_DIV   = B_W'(epd_pkg::EPD_ADC_MAX - 1);
    localparam logic [B_W-1:0] US_PER_S  = B_W'(1000000);
    localparam logic [R_W-1:0] POS_LIMIT = {{(R_W-A_W+1){1'b0}}, {(A_W-1){1'b1}}};
    localparam logic [R_W-1:0] NEG_LIMIT = POS_LIMIT + 1'b1;

    // Apply a sign to a 64-bit magnitude.
    function automatic logic signed [A_W:0] f_signed(input logic neg,
                                                    input logic [A_W-1:0] mag);
        logic signed [A_W:0] v;
        v = $signed({1'b0, mag});
        return neg ? -v : v;
    endfunction

    // Magnitude of a signed value, at most 2^64 - 1 in range of use.
    function automatic logic [A_W-1:0] f_abs(input logic signed [A_W:0] x);
        logic signed [A_W:0] v;
        v = x[A_W] ? -x : x;
        return v[A_W-1:0];
    endfunction

    // Clamp to the 32-bit signed range.
    function automatic logic signed [C_W-1:0] f_sat32(input logic signed [A_W+1:0] x);
        logic signed [C_W-1:0] r;
        if (x > $signed((A_W+2)'(32'h7FFF_FFFF))) begin
            r = {1'b0, {(C_W-1){1'b1}}};
        end else if (x < -$signed((A_W+2)'(33'h0_8000_0000))) begin
            r = {1'b1, {(C_W-1){1'b0}}};
        end else begin
            r = x[C_W-1:0];
        end
        return r;
    endfunction

    logic [ST_W-1:0]              r_state, n_state;
    logic                         r_go, n_go;
    logic [epd_pkg::EPD_ADC_W-1:0] r_adc;
    logic [epd_pkg::EPD_EL_W-1:0]  r_el;
    logic [A_W-1:0]               r_tmp, n_tmp;
    logic signed [C_W-1:0]        r_pos, n_pos;
    logic signed [C_W-1:0]        r_err, n_err;
    logic signed [C_W-1:0]        r_deriv, n_deriv;
    logic signed [C_W-1:0]        r_prev, n_prev;
    logic signed [C_W-1:0]        r_ctl, n_ctl;
    logic signed [A_W-1:0]        r_u, n_u;
    logic signed [A_W-1:0]        r_ets, n_ets;
    logic [epd_pkg::EPD_ANGLE_W-1:0] r_tgt_out, n_tgt_out;

    epd_pkg::t_alu_cmd            w_cmd;
    epd_pkg::t_alu_stat           w_alu;
    logic [R_W-1:0]               w_result;
    logic [A_W-1:0]               w_quot;
    logic signed [C_W:0]          w_diff;
    logic                         w_neg;
    logic signed [A_W:0]          w_sval;
    logic signed [A_W+1:0]        w_wide;
    logic signed [A_W:0]          w_target;
    logic [A_W-1:0]               w_fs;

    epd_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_stat   (w_alu),
        .o_result (w_result)
    );

    assign w_quot = w_result[R_W-1:B_W];
    assign w_diff = {r_err[C_W-1], r_err} - {r_prev[C_W-1], r_prev};
    assign w_fs   = (i_cfg.full_scale == '0) ? {{(A_W-1){1'b0}}, 1'b1}
                                             : {{(A_W-epd_pkg::EPD_ANGLE_W){1'b0}},
                                                i_cfg.full_scale};

    // Sign of the operand that the current step works on.
    always_comb begin
        unique case (r_state)
            ST_POS_MUL, ST_POS_DIV: w_neg = i_count[C_W-1];
            ST_TGT_MUL, ST_TGT_DIV: w_neg = (r_adc == '0);
            ST_DER_MUL, ST_DER_DIV: w_neg = w_diff[C_W];
            ST_ETS_MUL, ST_P_MUL:   w_neg = r_err[C_W-1];
            ST_D_MUL:               w_neg = r_deriv[C_W-1];
            ST_I_MUL, ST_I_DIV:     w_neg = r_ets[A_W-1];
            default:                w_neg = 1'b0;
        endcase
    end

    // Operand selection for the shared unit.
    always_comb begin
        w_cmd.start = r_go && !w_alu.busy && !w_alu.done
                      && !(r_state == ST_DER_MUL && r_el == '0);
        w_cmd.op    = epd_pkg::ALU_OP_MUL;
        w_cmd.a     = r_tmp;
        w_cmd.b     = '0;
        unique case (r_state)
            ST_POS_MUL: begin
                w_cmd.a = f_abs({{(A_W-C_W+1){i_count[C_W-1]}}, i_count});
                w_cmd.b = {{(B_W-epd_pkg::EPD_ANGLE_W){1'b0}}, i_cfg.angle_span};
            end
            ST_POS_DIV: begin
                w_cmd.op = epd_pkg::ALU_OP_DIV;
                w_cmd.b  = w_fs[B_W-1:0];
            end
            ST_TGT_MUL: begin
                w_cmd.a = (r_adc == '0) ? {{(A_W-1){1'b0}}, 1'b1}
                                        : {{(A_W-epd_pkg::EPD_ADC_W){1'b0}}, r_adc - 1'b1};
                w_cmd.b = {{(B_W-epd_pkg::EPD_ANGLE_W){1'b0}}, i_cfg.angle_span};
            end
            ST_TGT_DIV: begin
                w_cmd.op = epd_pkg::ALU_OP_DIV;
                w_cmd.b  = ADC_DIV;
            end
            ST_DER_MUL: begin
                w_cmd.a = f_abs({{(A_W-C_W){w_diff[C_W]}}, w_diff});
                w_cmd.b = US_PER_S;
            end
            ST_DER_DIV: begin
                w_cmd.op = epd_pkg::ALU_OP_DIV;
                w_cmd.b  = r_el;
            end
            ST_ETS_MUL: begin
                w_cmd.a = f_abs({{(A_W-C_W+1){r_err[C_W-1]}}, r_err});
                w_cmd.b = r_el;
            end
            ST_P_MUL: begin
                w_cmd.a = f_abs({{(A_W-C_W+1){r_err[C_W-1]}}, r_err});
                w_cmd.b = i_cfg.prop_gain;
            end
            ST_D_MUL: begin
                w_cmd.a = f_abs({{(A_W-C_W+1){r_deriv[C_W-1]}}, r_deriv});
                w_cmd.b = i_cfg.deriv_gain;
            end
            ST_I_MUL: begin
                w_cmd.a = f_abs({r_ets[A_W-1], r_ets});
                w_cmd.b = i_cfg.integ_gain;
            end
            ST_I_DIV: begin
                w_cmd.op = epd_pkg::ALU_OP_DIV;
                w_cmd.b  = US_PER_S;
            end
            default: begin
                w_cmd.start = 1'b0;
            end
        endcase
    end

    // Step sequencing and capture of each partial result.
    always_comb begin
        n_state   = r_state;
        n_go      = r_go && !w_cmd.start;
        n_tmp     = r_tmp;
        n_pos     = r_pos;
        n_err     = r_err;
        n_deriv   = r_deriv;
        n_prev    = r_prev;
        n_ctl     = r_ctl;
        n_u       = r_u;
        n_ets     = r_ets;
        n_tgt_out = r_tgt_out;
        w_sval    = f_signed(w_neg, w_result[A_W-1:0]);
        w_target  = f_signed(w_neg, w_quot);
        w_wide    = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_POS_MUL;
                    n_go    = 1'b1;
                end
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DER_MUL: begin
                // Zero elapsed time: the derivative saturates by the sign of the change.
                if (r_el == '0) begin
                    if (w_diff > 0) begin
                        n_deriv = {1'b0, {(C_W-1){1'b1}}};
                    end else if (w_diff < 0) begin
                        n_deriv = {1'b1, {(C_W-1){1'b0}}};
                    end else begin
                        n_deriv = '0;
                    end
                    n_state = ST_ETS_MUL;
                    n_go    = 1'b1;
                end else if (w_alu.done) begin
                    n_tmp   = w_result[A_W-1:0];
                    n_state = ST_DER_DIV;
                    n_go    = 1'b1;
                end
            end
            default: begin
                if (w_alu.done) begin
                    n_go = 1'b1;
                    unique case (r_state)
                        ST_POS_MUL: begin
                            n_tmp   = w_result[A_W-1:0];
                            n_state = ST_POS_DIV;
                        end
                        ST_POS_DIV: begin
                            n_pos   = f_sat32({w_target[A_W], w_target});
                            n_state = ST_TGT_MUL;
                        end
                        ST_TGT_MUL: begin
                            n_tmp   = w_result[A_W-1:0];
                            n_state = ST_TGT_DIV;
                        end
                        ST_TGT_DIV: begin
                            w_wide  = {w_target[A_W], w_target}
                                      - {{(A_W-C_W+2){r_pos[C_W-1]}}, r_pos};
                            n_err   = f_sat32(w_wide);
                            // The reported target is clamped to the angle range.
                            if (w_target[A_W]) begin
                                n_tgt_out = '0;
                            end else if (w_quot > A_W'({epd_pkg::EPD_ANGLE_W{1'b1}})) begin
                                n_tgt_out = '1;
                            end else begin
                                n_tgt_out = w_quot[epd_pkg::EPD_ANGLE_W-1:0];
                            end
                            n_state = ST_DER_MUL;
                        end
                        ST_DER_DIV: begin
                            n_deriv = f_sat32({w_target[A_W], w_target});
                            n_state = ST_ETS_MUL;
                        end
                        ST_ETS_MUL: begin
                            // Saturating accumulate of error times elapsed time.
                            w_wide = {{2{r_ets[A_W-1]}}, r_ets} + {w_sval[A_W], w_sval};
                            if (w_wide[A_W+1:A_W-1] == 3'b001
                                || w_wide[A_W+1:A_W-1] == 3'b010
                                || w_wide[A_W+1:A_W-1] == 3'b011) begin
                                n_ets = {1'b0, {(A_W-1){1'b1}}};
                            end else if (w_wide[A_W+1:A_W-1] == 3'b100
                                || w_wide[A_W+1:A_W-1] == 3'b101
                                || w_wide[A_W+1:A_W-1] == 3'b110) begin
                                n_ets = {1'b1, {(A_W-1){1'b0}}};
                            end else begin
                                n_ets = w_wide[A_W-1:0];
                            end
                            n_state = ST_P_MUL;
                        end
                        ST_P_MUL: begin
                            n_u     = w_sval[A_W-1:0];
                            n_state = ST_D_MUL;
                        end
                        ST_D_MUL: begin
                            w_wide  = {{2{r_u[A_W-1]}}, r_u} + {w_sval[A_W], w_sval};
                            n_u     = w_wide[A_W-1:0];
                            n_state = ST_I_MUL;
                        end
                        ST_I_MUL: begin
                            // Integral product saturates at the 64-bit limits.
                            if (!w_neg && w_result > POS_LIMIT) begin
                                n_tmp = POS_LIMIT[A_W-1:0];
                            end else if (w_neg && w_result > NEG_LIMIT) begin
                                n_tmp = NEG_LIMIT[A_W-1:0];
                            end else begin
                                n_tmp = w_result[A_W-1:0];
                            end
                            n_state = ST_I_DIV;
                        end
                        ST_I_DIV: begin
                            w_wide  = {{2{r_u[A_W-1]}}, r_u} + {w_target[A_W], w_target};
                            n_ctl   = f_sat32(w_wide);
                            n_prev  = r_err;
                            n_go    = 1'b0;
                            n_state = ST_DONE;
                        end
                        default: begin
                            n_go    = 1'b0;
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
        endcase
    end

    // Sequencer state and values kept between ticks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_go    <= 1'b0;
            r_prev  <= '0;
            r_ets   <= '0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            r_prev  <= n_prev;
            r_ets   <= n_ets;
        end
    end

    // Working registers of the current tick.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_adc <= i_adc;
            r_el  <= i_el;
        end
        r_tmp     <= n_tmp;
        r_pos     <= n_pos;
        r_err     <= n_err;
        r_deriv   <= n_deriv;
        r_ctl     <= n_ctl;
        r_u       <= n_u;
        r_tgt_out <= n_tgt_out;
    end

    assign o_stat.busy          = (r_state != ST_IDLE);
    assign o_stat.res_valid     = (r_state == ST_DONE);
    assign o_res.direction      = r_ctl[C_W-1];
    assign o_res.drive_level    = epd_pkg::EPD_DRIVE_FULL;
    assign o_res.control_value  = r_ctl;
    assign o_res.target_angle   = r_tgt_out;
    assign o_res.position_angle = r_pos;

    // The shared unit is never started while it is still working.
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.start |-> !w_alu.busy)
        else $error("arithmetic unit started while busy");

    // Results of the shared unit arrive only during a tick.
    a_done_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alu.done |-> (r_state != ST_IDLE && r_state != ST_DONE))
        else $error("arithmetic result outside a tick");

    // The previous error moves only at the last step of a tick.
    a_prev_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == ST_I_DIV && w_alu.done) |=> $stable(r_prev))
        else $error("previous error changed mid-tick");

endmodule

// ===== verif/encoder_position_pid_drive_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_position_pid_drive_core_tb: self-checking bench for the PID drive
// Drives encoder edges and control ticks through the input channel and
// rebuilds every drive result in a bit-accurate position PID model. A short
// directed table comes first, then random phases under several gain, scale
// and span settings. Both channels idle and stall at random, but not in the
// last phase. Each result is compared against the oldest pending prediction.
// ----------------------------------------------------------------------------
module encoder_position_pid_drive_core_tb;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        epd_pkg::t_in_item   item;
        bit                  known;
        epd_pkg::t_out_item  res;
    } t_row;

    localparam longint S64_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint S64_MIN   = 64'sh8000_0000_0000_0000;
    localparam longint S32_MAX   = 64'sd2147483647;
    localparam longint S32_MIN   = -64'sd2147483648;
    localparam longint US_PER_S  = 64'sd1000000;
    localparam longint ANGLE_MAX = 64'sd65535;

    // Register indexes past the last real register; writes there are dropped.
    localparam logic [epd_pkg::EPD_CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [epd_pkg::EPD_CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int PHASE_ITEMS = 115;
    localparam int EDGE_SETTLE = 16;
    localparam int TAIL_CYCLES = 500;
    localparam int QUIET_LIMIT = 4000;

    logic i_clk;
    logic i_rst_n;
    logic                               i_cfg_wr_en;
    logic [epd_pkg::EPD_CFG_IDX_W-1:0]  i_cfg_index;
    logic [epd_pkg::EPD_CFG_DATA_W-1:0] i_cfg_wdata;

    epd_in_if  item_if ();
    epd_out_if drive_if ();

    encoder_position_pid_drive_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (item_if),
        .o_out       (drive_if),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Model state: configuration mirror, encoder counter, PID memory.
    epd_pkg::t_cfg     cfg_now;
    logic [31:0]       enc_count;
    longint            prev_err;
    longint            err_time_sum;

    epd_pkg::t_out_item drive_due_q[$];
    int unsigned       mismatch_cnt;
    int unsigned       quiet_cycles;
    bit                idle_en;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint clamp64(input t_wide v);
        if (v > t_wide'(S64_MAX)) return S64_MAX;
        if (v < t_wide'(S64_MIN)) return S64_MIN;
        return v[63:0];
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    // Signed term times unsigned Q8.16 gain, held to the 64-bit limits.
    function automatic longint gain_mul(input longint a,
                                        input logic [epd_pkg::EPD_GAIN_W-1:0] g);
        t_wide gw;
        gw = g;
        return clamp64(t_wide'(a) * gw);
    endfunction

    // Advances the drive model by one accepted item; ticks yield a result.
    task automatic advance_drive_model(input epd_pkg::t_in_item it, output bit has_res,
                                       output epd_pkg::t_out_item res);
        longint fs, tgt, pos, err, diff, drv, u, el;
        has_res = 1'b0;
        res     = '0;
        if (it.op == epd_pkg::OP_ENC_EDGE) begin
            if (it.phase_b_level) enc_count = enc_count + 32'd1;
            else                  enc_count = enc_count - 32'd1;
            return;
        end
        el  = longint'(it.elapsed_us);
        fs  = (cfg_now.full_scale == '0) ? 64'sd1 : longint'(cfg_now.full_scale);
        tgt = (longint'(it.target_adc) - 1) * longint'(cfg_now.angle_span)
              / longint'(epd_pkg::EPD_ADC_MAX - 1);
        pos = clamp32(longint'($signed(enc_count)) * longint'(cfg_now.angle_span) / fs);
        err = clamp32(tgt - pos);
        diff = err - prev_err;
        // With no elapsed time the derivative pins to the rail of its sign.
        if (el == 0) begin
            drv = (diff > 0) ? S32_MAX : ((diff < 0) ? S32_MIN : 64'sd0);
        end else begin
            drv = clamp32(diff * US_PER_S / el);
        end
        err_time_sum = clamp64(t_wide'(err_time_sum) + t_wide'(err * el));
        u = clamp64(t_wide'(gain_mul(err, cfg_now.prop_gain))
                    + t_wide'(gain_mul(drv, cfg_now.deriv_gain)));
        u = clamp64(t_wide'(u)
                    + t_wide'(gain_mul(err_time_sum, cfg_now.integ_gain) / US_PER_S));
        u = clamp32(u);
        prev_err = err;

        has_res             = 1'b1;
        res.direction       = (u < 0);
        res.drive_level     = epd_pkg::EPD_DRIVE_FULL;
        res.control_value   = u[31:0];
        res.target_angle    = (tgt < 0) ? '0 : ((tgt > ANGLE_MAX) ? 16'hFFFF : tgt[15:0]);
        res.position_angle  = pos[31:0];
    endtask

    function automatic t_row edge_row(input logic up);
        t_row r;
        r.item.op            = epd_pkg::OP_ENC_EDGE;
        r.item.phase_b_level = up;
        r.item.target_adc    = epd_pkg::EPD_ADC_W'($urandom);
        r.item.elapsed_us    = epd_pkg::EPD_EL_W'($urandom);
        r.known              = 1'b0;
        r.res                = '0;
        return r;
    endfunction

    function automatic t_row tick_row(input logic [epd_pkg::EPD_ADC_W-1:0] adc,
                                      input logic [epd_pkg::EPD_EL_W-1:0] el);
        t_row r;
        r.item.op            = epd_pkg::OP_TICK;
        r.item.phase_b_level = 1'($urandom);
        r.item.target_adc    = adc;
        r.item.elapsed_us    = el;
        r.known              = 1'b0;
        r.res                = '0;
        return r;
    endfunction

    function automatic t_row known_tick(input logic [epd_pkg::EPD_ADC_W-1:0] adc,
                                        input logic [epd_pkg::EPD_EL_W-1:0] el,
                                        input logic dir, input logic [31:0] ctl,
                                        input logic [15:0] tgt, input logic [31:0] pos);
        t_row r;
        r = tick_row(adc, el);
        r.known              = 1'b1;
        r.res.direction      = dir;
        r.res.drive_level    = epd_pkg::EPD_DRIVE_FULL;
        r.res.control_value  = ctl;
        r.res.target_angle   = tgt;
        r.res.position_angle = pos;
        return r;
    endfunction

    // Target samples lean toward the ends of the converter range.
    function automatic logic [epd_pkg::EPD_ADC_W-1:0] pick_adc();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 10'h3FF;
            2: return epd_pkg::EPD_ADC_W'($urandom_range(0, 3));
            default: return epd_pkg::EPD_ADC_W'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [epd_pkg::EPD_EL_W-1:0] pick_elapsed();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 24'hFFFFFF;
            2, 3: return epd_pkg::EPD_EL_W'($urandom);
            default: return epd_pkg::EPD_EL_W'($urandom_range(1, 2000));
        endcase
    endfunction

    // Offers one item, waits for the transaction, then records the prediction.
    task automatic send_item(input t_row r);
        epd_pkg::t_out_item res;
        bit                 has_res;
        int unsigned        gap;
        if (idle_en && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 17);
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.data  <= r.item;
        do @(posedge i_clk); while (!item_if.ready);
        advance_drive_model(r.item, has_res, res);
        if (has_res) drive_due_q.push_back(r.known ? r.res : res);
    endtask

    task automatic cfg_write(input logic [epd_pkg::EPD_CFG_IDX_W-1:0] idx,
                             input logic [epd_pkg::EPD_CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            epd_pkg::CFG_PROP_GAIN:  cfg_now.prop_gain  = data;
            epd_pkg::CFG_DERIV_GAIN: cfg_now.deriv_gain = data;
            epd_pkg::CFG_INTEG_GAIN: cfg_now.integ_gain = data;
            epd_pkg::CFG_FULL_SCALE: cfg_now.full_scale = data[15:0];
            epd_pkg::CFG_ANGLE_SPAN: cfg_now.angle_span = data[15:0];
            default: ;
        endcase
    endtask

    // Loads a full register set; 16-bit registers get junk in the upper bits.
    task automatic write_regs(input epd_pkg::t_cfg c,
                              input logic [epd_pkg::EPD_CFG_IDX_W-1:0] spare);
        cfg_write(epd_pkg::CFG_PROP_GAIN,  c.prop_gain);
        cfg_write(epd_pkg::CFG_DERIV_GAIN, c.deriv_gain);
        cfg_write(epd_pkg::CFG_INTEG_GAIN, c.integ_gain);
        cfg_write(epd_pkg::CFG_FULL_SCALE, {8'($urandom), c.full_scale});
        cfg_write(epd_pkg::CFG_ANGLE_SPAN, {8'($urandom), c.angle_span});
        cfg_write(spare, epd_pkg::EPD_CFG_DATA_W'($urandom));
        i_cfg_wr_en <= 1'b0;
    endtask

    // Waits until every pending result is back and any edge has landed.
    task automatic settle();
        item_if.valid <= 1'b0;
        while (drive_due_q.size() != 0) @(posedge i_clk);
        repeat (EDGE_SETTLE) @(posedge i_clk);
    endtask

    // Random bursts of encoder edges, each followed by a control tick.
    task automatic run_random(input int n_items);
        int  sent;
        int  burst;
        bit  up;
        sent = 0;
        up   = 1'($urandom);
        while (sent < n_items) begin
            if ($urandom_range(0, 3) == 0) up = ~up;
            burst = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            repeat (burst) begin
                if ($urandom_range(0, 4) == 0) send_item(edge_row(1'($urandom)));
                else                           send_item(edge_row(up));
            end
            send_item(tick_row(pick_adc(), pick_elapsed()));
            sent += burst + 1;
        end
    endtask

    // Result side: held off during reset, then random stall bursts while
    // idling is enabled.
    always @(posedge i_clk) begin : result_stall
        int unsigned hold_cnt;
        if (!i_rst_n) begin
            hold_cnt = 0;
            drive_if.ready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt = hold_cnt - 1;
            drive_if.ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 11) == 0) begin
            hold_cnt = $urandom_range(1, 17) - 1;
            drive_if.ready <= 1'b0;
        end else begin
            drive_if.ready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest pending prediction.
    always @(posedge i_clk) begin : result_check
        epd_pkg::t_out_item want;
        epd_pkg::t_out_item got;
        if (i_rst_n && drive_if.valid && drive_if.ready) begin
            got = drive_if.data;
            if (drive_due_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display({"[%0t] result with nothing pending: ",
                              "dir %0d drv %0d ctl %0d tgt %0d pos %0d"},
                             $realtime, got.direction, got.drive_level, got.control_value,
                             got.target_angle, got.position_angle);
            end else begin
                want = drive_due_q.pop_front();
                if (got.direction !== want.direction || got.drive_level !== want.drive_level ||
                    got.control_value !== want.control_value ||
                    got.target_angle !== want.target_angle ||
                    got.position_angle !== want.position_angle) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("[%0t] mismatch exp: dir %0d drv %0d ctl %0d tgt %0d pos %0d",
                                 $realtime, want.direction, want.drive_level,
                                 want.control_value, want.target_angle, want.position_angle);
                        $display("[%0t] mismatch got: dir %0d drv %0d ctl %0d tgt %0d pos %0d",
                                 $realtime, got.direction, got.drive_level,
                                 got.control_value, got.target_angle, got.position_angle);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run after too long without any transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_if.valid && item_if.ready) || (drive_if.valid && drive_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("encoder_position_pid_drive_core_tb: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        t_row          rows[$];
        epd_pkg::t_cfg c;
        i_rst_n       <= 1'b0;
        item_if.valid <= 1'b0;
        item_if.data  <= '0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_wdata   <= '0;
        idle_en       = 1'b1;

        cfg_now.prop_gain  = epd_pkg::RST_PROP_GAIN;
        cfg_now.deriv_gain = epd_pkg::RST_DERIV_GAIN;
        cfg_now.integ_gain = epd_pkg::RST_INTEG_GAIN;
        cfg_now.full_scale = epd_pkg::RST_FULL_SCALE;
        cfg_now.angle_span = epd_pkg::RST_ANGLE_SPAN;
        enc_count    = '0;
        prev_err     = 0;
        err_time_sum = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table at reset defaults. Rows with a typed result cover the
        // cleared state, both derivative rails on zero elapsed time, and a zero
        // elapsed time with no error change.
        rows.push_back(known_tick(10'd1, 24'd1000, 1'b0, 32'd0, 16'd0, 32'd0));
        rows.push_back(known_tick(10'h3FF, 24'd0, 1'b0, 32'h7FFF_FFFF, 16'd180, 32'd0));
        rows.push_back(known_tick(10'd0, 24'd0, 1'b1, 32'h8000_0000, 16'd0, 32'd0));
        rows.push_back(known_tick(10'd0, 24'd0, 1'b0, 32'd0, 16'd0, 32'd0));
        repeat (5) rows.push_back(edge_row(1'b1));
        rows.push_back(tick_row(10'd512, 24'd1));
        repeat (3) rows.push_back(edge_row(1'b0));
        rows.push_back(tick_row(10'h3FF, 24'hFFFFFF));
        rows.push_back(tick_row(10'd0, 24'hFFFFFF));
        repeat (4) rows.push_back(edge_row(1'b0));
        rows.push_back(tick_row(10'd2, 24'd1));
        rows.push_back(tick_row(10'd1022, 24'h800000));
        rows.push_back(tick_row(10'd1, 24'd0));
        foreach (rows[k]) send_item(rows[k]);

        run_random(PHASE_ITEMS);

        // All gains, scale and span at their maximum.
        settle();
        c.prop_gain  = 24'hFFFFFF;
        c.deriv_gain = 24'hFFFFFF;
        c.integ_gain = 24'hFFFFFF;
        c.full_scale = 16'hFFFF;
        c.angle_span = 16'hFFFF;
        write_regs(c, CFG_SPARE_LO);
        run_random(PHASE_ITEMS);

        // Zero gains and the smallest scale and span.
        settle();
        c.prop_gain  = '0;
        c.deriv_gain = '0;
        c.integ_gain = '0;
        c.full_scale = 16'd1;
        c.angle_span = 16'd1;
        write_regs(c, CFG_SPARE_HI);
        run_random(PHASE_ITEMS);

        // Zero full scale acts as one; wide span drives the target negative.
        settle();
        c.prop_gain  = epd_pkg::EPD_GAIN_W'($urandom);
        c.deriv_gain = epd_pkg::EPD_GAIN_W'($urandom);
        c.integ_gain = epd_pkg::EPD_GAIN_W'($urandom);
        c.full_scale = '0;
        c.angle_span = 16'hFFFF;
        write_regs(c, CFG_SPARE_LO);
        run_random(PHASE_ITEMS);

        // Fully random register set.
        settle();
        c.prop_gain  = epd_pkg::EPD_GAIN_W'($urandom);
        c.deriv_gain = epd_pkg::EPD_GAIN_W'($urandom);
        c.integ_gain = epd_pkg::EPD_GAIN_W'($urandom);
        c.full_scale = epd_pkg::EPD_ANGLE_W'($urandom_range(1, 65535));
        c.angle_span = epd_pkg::EPD_ANGLE_W'($urandom_range(1, 65535));
        write_regs(c, CFG_SPARE_HI);
        run_random(PHASE_ITEMS);

        // Moderate gains, span just past the converter range, no idling.
        settle();
        idle_en = 1'b0;
        c.prop_gain  = epd_pkg::EPD_GAIN_W'($urandom_range(0, 131072));
        c.deriv_gain = epd_pkg::EPD_GAIN_W'($urandom_range(0, 8192));
        c.integ_gain = epd_pkg::EPD_GAIN_W'($urandom_range(0, 65536));
        c.full_scale = epd_pkg::EPD_ANGLE_W'($urandom_range(1, 64));
        c.angle_span = epd_pkg::EPD_ANGLE_W'($urandom_range(1022, 4000));
        write_regs(c, CFG_SPARE_LO);
        run_random(PHASE_ITEMS);

        item_if.valid <= 1'b0;
        while (drive_due_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && drive_due_q.size() == 0) begin
            $display("encoder_position_pid_drive_core_tb: PASS");
        end else begin
            $display("encoder_position_pid_drive_core_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/epd_pkg.sv
rtl/epd_in_if.sv
rtl/epd_out_if.sv
rtl/epd_alu.sv
rtl/epd_ctrl.sv
rtl/encoder_position_pid_drive_core.sv
verif/encoder_position_pid_drive_core_tb.sv
